>>> design/urldec_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
package urldec_pkg;

    localparam int NUM_OUT = 3;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    // Results caused by one input byte, in emit order from data[0].
    typedef struct packed {
        logic [NUM_OUT-1:0][7:0] data;
        logic [1:0]              count;
        logic                    last;
    } burst_t;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CHAR_0) && (b <= CHAR_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = is_digit(b) ||
                 ((b >= CHAR_LA) && (b <= CHAR_LF)) ||
                 ((b >= CHAR_UA) && (b <= CHAR_UF));
    endfunction

    // Nibble value of a byte known to be a hex digit; letters map via low nibble + 9.
    function automatic logic [3:0] nibble_val(input logic [7:0] b);
        if (is_digit(b))
        begin
            nibble_val = b[3:0];
        end
        else
        begin
            nibble_val = b[3:0] + 4'd9;
        end
    endfunction

endpackage

>>> design/urldec_core.sv
// Escape tracking and per-byte decode: turns one input byte into a burst of 0-3 results.
module urldec_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                take,
    output urldec_pkg::burst_t  burst
);
    import urldec_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic [1:0] pfx_cnt;
    logic [7:0] pfx0, pfx1;
    logic       plain_on;
    logic [7:0] plain_byte;
    logic       plain_opens;

    // Plain handling of the current byte: '%' opens an escape unless it is the last byte.
    assign plain_opens = (in_byte == CHAR_PCT) && !in_last;
    assign plain_byte  = (in_byte == CHAR_PLUS) ? CHAR_SPACE : in_byte;

    always_comb
    begin
        phase_next = PH_IDLE;
        held_next  = held_reg;
        pfx_cnt    = 2'd0;
        pfx0       = CHAR_PCT;
        pfx1       = held_reg;
        plain_on   = 1'b1;

        unique case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(in_byte) && !in_last)
                begin
                    held_next = in_byte;
                    phase_next = PH_DIGIT;
                    plain_on = 1'b0;
                end
                else
                begin
                    pfx_cnt = 2'd1;
                end
            end
            PH_DIGIT:
            begin
                if (is_hex(held_reg) && is_hex(in_byte))
                begin
                    pfx_cnt  = 2'd1;
                    pfx0     = {nibble_val(held_reg), nibble_val(in_byte)};
                    plain_on = 1'b0;
                end
                else
                begin
                    pfx_cnt = 2'd2;
                end
                held_next = 8'd0;
            end
            default:
            begin
                pfx_cnt = 2'd0;
            end
        endcase

        if (plain_on && plain_opens)
        begin
            phase_next = PH_PCT;
            plain_on   = 1'b0;
        end

        if (in_last)
        begin
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end
    end

    // Pack prefix bytes and the plain byte into the burst.
    always_comb
    begin
        burst.data    = '0;
        burst.data[0] = pfx0;
        burst.data[1] = pfx1;
        burst.last    = in_last;
        burst.count   = pfx_cnt + {1'b0, plain_on};
        if (plain_on)
        begin
            unique case (pfx_cnt)
                2'd0:    burst.data[0] = plain_byte;
                2'd1:    burst.data[1] = plain_byte;
                default: burst.data[2] = plain_byte;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> design/url_percent_decoder_unit.sv
// Top level of the URL percent decoder: byte decode plus a three-entry result buffer.
//
// Decodes form-urlencoded text one byte per transfer: "%hh" becomes one byte, '+' becomes
// a space, broken or truncated escapes pass through literally, and in_last closes the
// text. Each input byte yields zero to three results, each marked run_end on the last
// result of that byte and text_end on the final byte of the text. The input side takes
// one byte per cycle while in_stall is low: the byte is decoded in the cycle it is taken and
// its results land in a three-entry result buffer that drains one result per cycle while
// out_stall is low, so first results show in the cycle after the input transfer. A byte that
// yields two or three results holds in_stall while the buffer drains; the buffer drain (one
// output transfer per cycle while out_stall is low) is what sets the sustained rate. A new
// byte is taken in the same cycle the last buffered result transfers, so no bubble is added.
// in_stall is high only while results are buffered.
module url_percent_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       text_end
);
    import urldec_pkg::*;

    burst_t burst;
    logic   take;
    logic   out_xfer;

    // Result buffer: entry 0 is the result on the port; shifts down on each transfer.
    logic [NUM_OUT-1:0][7:0] data_reg;
    logic [1:0]              remain_reg;
    logic                    last_reg;

    // Busy unless empty, or the final buffered result transfers this cycle.
    assign in_stall = (remain_reg > 2'd1) || ((remain_reg == 2'd1) && out_stall);
    assign take     = in_valid && !in_stall;

    assign out_valid = (remain_reg != 2'd0);
    assign out_xfer  = out_valid && !out_stall;
    assign out_byte  = data_reg[0];
    assign run_end   = (remain_reg == 2'd1);
    assign text_end  = (remain_reg == 2'd1) && last_reg;

    urldec_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte),
        .in_last (in_last),
        .take    (take),
        .burst   (burst)
    );

    // Payload: loaded with a new burst, else shifted on each transfer.
    always_ff @(posedge clk)
    begin
        if (take && (burst.count != 2'd0))
        begin
            data_reg <= burst.data;
            last_reg <= burst.last;
        end
        else if (out_xfer)
        begin
            data_reg[0] <= data_reg[1];
            data_reg[1] <= data_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 2'd0;
        end
        else if (take && (burst.count != 2'd0))
        begin
            remain_reg <= burst.count;
        end
        else if (out_xfer)
        begin
            remain_reg <= remain_reg - 2'd1;
        end
    end

endmodule

>>> design/urldec_checker.sv
// Port-level checks for the URL percent decoder, bound to the top level.
module urldec_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_end,
    input logic       text_end
);

    // Stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_end)
                                   && $stable(text_end))
        else $error("result changed while stalled");

    // Input only stalls while results are buffered.
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result buffer");

    // A burst is delivered without gaps up to its run_end.
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_end |=> out_valid)
        else $error("burst broken before run_end");

    // End of text always closes a run.
    a_text_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_end)
        else $error("text_end without run_end");

endmodule

bind url_percent_decoder_unit urldec_checker u_urldec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .text_end  (text_end)
);

>>> tb/testbench.sv
// Self-checking testbench for the URL percent decoder unit.
`timescale 1ns / 1ps

module testbench;
    import urldec_pkg::*;

    // Run shape
    localparam int NUM_DIR      = 24;
    localparam int RANDOM_ITEMS = 350;
    localparam int QUIET_ITEMS  = 50;      // tail of the run with no idling
    localparam int HOLD_AT      = 100;     // random item that triggers the long output hold-off
    localparam int HOLD_CYCLES  = 48;
    localparam int PAUSE_AT     = 220;     // random item before which the sender drains
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;

    // Escape tracking of the predictor; the RTL never reaches code 3.
    typedef enum logic [1:0]
    {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } esc_phase_t;

    // One decoded result as it should appear on the output channel.
    typedef struct packed
    {
        logic [7:0] data;
        logic       run_end;
        logic       text_end;
    } dec_out_t;

    // One row of the directed table. want[0] is the first result.
    typedef struct packed
    {
        logic [7:0]      b;
        logic            l;
        logic            typed;
        logic [1:0]      cnt;
        logic [2:0][7:0] want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;

    // Predictor state
    esc_phase_t esc_state;
    logic [7:0] held_hex;
    logic [7:0] step_bytes[$];      // bytes decoded from the latest accepted input

    dec_out_t   pending_bytes[$];   // decoded bytes still owed by the block
    int         error_count;
    int         cycle_count;
    bit         quiet;              // no idling on either side
    bit         hold_off_req;       // sender asks the receiver for a long hold-off

    stim_row_t  dir_rows[NUM_DIR];

    url_percent_decoder_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_end   (run_end),
        .text_end  (text_end)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Hex digit value, or -1 for anything that is not 0-9, a-f, A-F.
    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= CHAR_0 && b <= CHAR_9)
        begin
            return int'(b - CHAR_0);
        end
        if (b >= CHAR_LA && b <= CHAR_LF)
        begin
            return int'(b - CHAR_LA) + 10;
        end
        if (b >= CHAR_UA && b <= CHAR_UF)
        begin
            return int'(b - CHAR_UA) + 10;
        end
        return -1;
    endfunction

    // Unescaped handling: '%' opens an escape unless it closes the text, '+' is a space.
    function automatic void plain_byte(input logic [7:0] b, input logic l);
        if (b == CHAR_PCT && !l)
        begin
            esc_state = ESC_PCT;
        end
        else
        begin
            step_bytes = {step_bytes, ((b == CHAR_PLUS) ? CHAR_SPACE : b)};
        end
    endfunction

    // Advance the predictor by one input byte; results land in step_bytes.
    function automatic void decode_byte(input logic [7:0] b, input logic l);
        esc_phase_t phase;
        int         hi;
        int         lo;
        logic [7:0] joined;
        phase = esc_state;
        esc_state = ESC_NONE;
        step_bytes.delete();
        case (phase)
            ESC_PCT:
            begin
                if (hex_nibble(b) >= 0 && !l)
                begin
                    held_hex = b;
                    esc_state = ESC_DIGIT;
                end
                else
                begin
                    // broken or truncated escape: '%' goes out as is
                    step_bytes = {step_bytes, CHAR_PCT};
                    plain_byte(b, l);
                end
            end
            ESC_DIGIT:
            begin
                hi = hex_nibble(held_hex);
                lo = hex_nibble(b);
                if (hi >= 0 && lo >= 0)
                begin
                    joined = {hi[3:0], lo[3:0]};
                    step_bytes = {step_bytes, joined};
                end
                else
                begin
                    step_bytes = {step_bytes, CHAR_PCT};
                    step_bytes = {step_bytes, held_hex};
                    plain_byte(b, l);
                end
                held_hex = '0;
            end
            default:
            begin
                plain_byte(b, l);
            end
        endcase
        if (l)
        begin
            esc_state = ESC_NONE;
            held_hex = '0;
        end
    endfunction

    function automatic stim_row_t mk_row(input logic typed, input logic [7:0] b,
                                         input logic l, input logic [1:0] cnt,
                                         input logic [7:0] w0, input logic [7:0] w1,
                                         input logic [7:0] w2);
        stim_row_t r;
        r.b     = b;
        r.l     = l;
        r.typed = typed;
        r.cnt   = cnt;
        r.want  = {w2, w1, w0};
        return r;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10)
        begin
            return CHAR_0 + v;
        end
        return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + v - 4'd10;
    endfunction

    // Offer one byte, wait for the transfer, then record what it must decode to.
    // Typed rows override the predictor output with hand-written results; the
    // predictor still runs so its escape state stays in step with the block.
    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input logic [1:0] cnt, input logic [2:0][7:0] want);
        dec_out_t r;
        int       n;
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        decode_byte(b, l);
        if (typed)
        begin
            step_bytes.delete();
            for (int i = 0; i < cnt; i++)
            begin
                step_bytes = {step_bytes, want[i]};
            end
        end
        n = step_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            r.data     = step_bytes[i];
            r.run_end  = (i == n - 1);
            r.text_end = l && (i == n - 1);
            pending_bytes = {pending_bytes, r};
        end
        // occasional idle burst on the input side
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every owed result; always advances at least one edge
    // so valid is never lowered and raised in one step.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_bytes.size() != 0);
    endtask

    // Sender: reset, directed table, random texts, drain, verdict.
    initial
    begin : sender
        logic [7:0] text_q[$];
        int         sent;
        int         pieces;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = '0;
        in_last     = 1'b0;
        esc_state   = ESC_NONE;
        held_hex    = '0;
        error_count = 0;
        quiet       = 1'b0;
        hold_off_req = 1'b0;
        sent        = 0;

        // Directed rows. Typed expectations only where they read straight off the rules.
        dir_rows[0]  = mk_row(1'b1, CHAR_PLUS, 1'b0, 2'd1, CHAR_SPACE, 8'h00, 8'h00);
        dir_rows[1]  = mk_row(1'b1, 8'h00, 1'b0, 2'd1, 8'h00, 8'h00, 8'h00);
        dir_rows[2]  = mk_row(1'b1, 8'hFF, 1'b0, 2'd1, 8'hFF, 8'h00, 8'h00);
        // "%fF" decodes through the predictor
        dir_rows[3]  = mk_row(1'b0, CHAR_PCT, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[4]  = mk_row(1'b0, "f", 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[5]  = mk_row(1'b0, "F", 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        // "%00": silent, silent, then a zero byte
        dir_rows[6]  = mk_row(1'b1, CHAR_PCT, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[7]  = mk_row(1'b1, "0", 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[8]  = mk_row(1'b1, "0", 1'b0, 2'd1, 8'h00, 8'h00, 8'h00);
        // '%' broken by a non-hex byte
        dir_rows[9]  = mk_row(1'b1, CHAR_PCT, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[10] = mk_row(1'b1, "G", 1'b0, 2'd2, CHAR_PCT, "G", 8'h00);
        // '%' plus digit broken: three results from one byte
        dir_rows[11] = mk_row(1'b1, CHAR_PCT, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[12] = mk_row(1'b1, "a", 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[13] = mk_row(1'b1, "z", 1'b0, 2'd3, CHAR_PCT, "a", "z");
        // breaking byte is itself '%' and opens a new escape, then a '+' ends the text
        dir_rows[14] = mk_row(1'b1, CHAR_PCT, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[15] = mk_row(1'b1, "9", 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[16] = mk_row(1'b1, CHAR_PCT, 1'b0, 2'd2, CHAR_PCT, "9", 8'h00);
        dir_rows[17] = mk_row(1'b1, CHAR_PLUS, 1'b1, 2'd2, CHAR_PCT, CHAR_SPACE, 8'h00);
        // one-byte text that is just '%'
        dir_rows[18] = mk_row(1'b1, CHAR_PCT, 1'b1, 2'd1, CHAR_PCT, 8'h00, 8'h00);
        // hex digit arriving as the last byte cannot complete the escape
        dir_rows[19] = mk_row(1'b1, CHAR_PCT, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[20] = mk_row(1'b1, "B", 1'b1, 2'd2, CHAR_PCT, "B", 8'h00);
        // '%' plus digit pending and a final '%'
        dir_rows[21] = mk_row(1'b1, CHAR_PCT, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[22] = mk_row(1'b1, "4", 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        dir_rows[23] = mk_row(1'b1, CHAR_PCT, 1'b1, 2'd3, CHAR_PCT, "4", CHAR_PCT);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            send_byte(dir_rows[k].b, dir_rows[k].l, dir_rows[k].typed,
                      dir_rows[k].cnt, dir_rows[k].want);
        end
        wait_drained();

        // Random texts: well-formed escapes with random content, plus noise.
        while (sent < RANDOM_ITEMS)
        begin
            text_q.delete();
            pieces = $urandom_range(1, 8);
            repeat (pieces)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        text_q = {text_q, CHAR_PCT};
                        text_q = {text_q, rand_hex_char()};
                        text_q = {text_q, rand_hex_char()};
                    end
                    4:
                    begin
                        text_q = {text_q, CHAR_PLUS};
                    end
                    5:
                    begin
                        // '%' then anything: usually a broken escape
                        text_q = {text_q, CHAR_PCT};
                        text_q = {text_q, 8'($urandom_range(0, 255))};
                    end
                    6:
                    begin
                        text_q = {text_q, CHAR_PCT};
                    end
                    default:
                    begin
                        text_q = {text_q, 8'($urandom_range(0, 255))};
                    end
                endcase
            end
            for (int k = 0; k < text_q.size(); k++)
            begin
                if (sent == HOLD_AT)
                begin
                    // receiver freezes; sender keeps offering until the block pushes back
                    hold_off_req = 1'b1;
                end
                if (sent == PAUSE_AT)
                begin
                    wait_drained();
                end
                if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                begin
                    quiet = 1'b1;
                end
                send_byte(text_q[k], k == text_q.size() - 1, 1'b0, 2'd0, '0);
                sent++;
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none in the quiet tail.
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Output transfers are compared in order against the oldest owed result.
    always @(posedge clk)
    begin : result_check
        dec_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result byte 0x%02h", out_byte));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.data)
                begin
                    report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                              out_byte, want.data));
                end
                if (run_end !== want.run_end)
                begin
                    report_mismatch($sformatf("run_end %b, expected %b (byte 0x%02h)",
                                              run_end, want.run_end, want.data));
                end
                if (text_end !== want.text_end)
                begin
                    report_mismatch($sformatf("text_end %b, expected %b (byte 0x%02h)",
                                              text_end, want.text_end, want.data));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : cycle_watch
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
    end

endmodule
